FILE: hdl/program_stream_pes_filter_assert.svh
// Assertion macros for the filter RTL.
`ifndef PROGRAM_STREAM_PES_FILTER_ASSERT_SVH
`define PROGRAM_STREAM_PES_FILTER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/psf_pkg.sv
`timescale 1ns / 1ps

package psf_pkg;

    // Parser phases, one-hot
    typedef enum logic [15:0] {
        PH_HUNT     = 16'h0001,
        PH_CODE     = 16'h0002,
        PH_PACK1    = 16'h0004,
        PH_PACK2    = 16'h0008,
        PH_SKIP     = 16'h0010,
        PH_LENHI    = 16'h0020,
        PH_LENLO    = 16'h0040,
        PH_PESFIRST = 16'h0080,
        PH_M2FLAGS2 = 16'h0100,
        PH_M2HLEN   = 16'h0200,
        PH_HDRSKIP  = 16'h0400,
        PH_M1STD2   = 16'h0800,
        PH_M1PTS    = 16'h1000,
        PH_PRIV     = 16'h2000,
        PH_PAYLOAD  = 16'h4000,
        PH_M1STUFF  = 16'h8000
    } psf_phase_t;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_MALFORMED = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] CFG_IDX_STREAM    = 1'b0;
    localparam logic [0:0] CFG_IDX_SUBSTREAM = 1'b1;

    localparam logic [7:0] TARGET_STREAM_RESET    = 8'hE0;
    localparam logic [7:0] TARGET_SUBSTREAM_RESET = 8'h00;

    // Start codes and stream ids
    localparam logic [7:0] CODE_PROGRAM_END  = 8'hB9;
    localparam logic [7:0] CODE_PACK         = 8'hBA;
    localparam logic [7:0] CODE_SYSTEM_HDR   = 8'hBB;
    localparam logic [7:0] SID_PRIVATE_1     = 8'hBD;
    localparam logic [7:0] BYTE_STUFFING     = 8'hFF;
    localparam logic [7:0] PTS_NONE          = 8'h0F;
    localparam logic [7:0] PTS_DTS_THRESHOLD = 8'h30;
    localparam logic [7:0] PTS_THRESHOLD     = 8'h20;
    localparam logic [7:0] PTS_DTS_BYTES     = 8'd9;
    localparam logic [7:0] PTS_BYTES         = 8'd4;
    localparam logic [3:0] PACK2_LAST_FIELD  = 4'd9;
    localparam logic [3:0] PRIV_LAST_FIELD   = 4'd3;
    localparam logic [15:0] PACK1_SKIP       = 16'd7;

    // One result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] chunk_len;
        logic        last;
    } psf_result_t;

    // Stream ids whose packets are skipped whole
    function automatic logic is_reserved(input logic [7:0] id);
        return (id == 8'hBC) || (id == 8'hBE) || (id == 8'hBF) || (id == 8'hF0) ||
               (id == 8'hF1) || (id == 8'hF2) || (id == 8'hF8) || (id == 8'hFF);
    endfunction

endpackage

FILE: hdl/psf_parser.sv
`timescale 1ns / 1ps

module psf_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_valid,
    input  logic [7:0]          byte_in,
    input  logic [7:0]          target_sid,
    input  logic [7:0]          target_sub,
    output logic                res_valid,
    output psf_pkg::psf_result_t res
);
    import psf_pkg::*;

    psf_phase_t  phase_reg, phase_next;
    logic [15:0] recent_reg, recent_next;
    logic [7:0]  sid_reg, sid_next;
    logic [7:0]  sub_reg, sub_next;
    logic [15:0] pkt_len_reg, pkt_len_next;
    logic [15:0] hdr_used_reg, hdr_used_next;
    logic [15:0] skip_reg, skip_next;
    logic [3:0]  field_reg, field_next;
    logic        match_reg, match_next;
    logic [15:0] pay_rem_reg, pay_rem_next;

    logic        hdr_full;
    logic [15:0] left_after;
    logic [15:0] skip_dec;
    logic [15:0] pay_dec;
    logic [15:0] lenlo_val;
    logic        req_hunt, req_bad, req_end;
    logic        req_hdr_skip, req_hdr_done, req_start, req_skip_hunt, req_pts;
    logic        hdr_done_path;
    logic [7:0]  hdr_skip_n;
    logic [15:0] skip_hunt_n;
    logic [7:0]  sub_eff;

    // Header byte bookkeeping shared by all header phases
    assign hdr_full   = (hdr_used_reg >= pkt_len_reg);
    assign left_after = pkt_len_reg + ~hdr_used_reg;
    assign skip_dec   = skip_reg - 16'd1;
    assign pay_dec    = pay_rem_reg - 16'd1;
    assign lenlo_val  = {skip_reg[15:8], byte_in};

    // Per-phase decode, then shared actions
    always_comb begin
        phase_next    = phase_reg;
        recent_next   = recent_reg;
        sid_next      = sid_reg;
        sub_next      = sub_reg;
        pkt_len_next  = pkt_len_reg;
        hdr_used_next = hdr_used_reg;
        skip_next     = skip_reg;
        field_next    = field_reg;
        match_next    = match_reg;
        pay_rem_next  = pay_rem_reg;
        req_hunt      = 1'b0;
        req_bad       = 1'b0;
        req_end       = 1'b0;
        req_hdr_skip  = 1'b0;
        req_hdr_done  = 1'b0;
        req_start     = 1'b0;
        req_skip_hunt = 1'b0;
        req_pts       = 1'b0;
        hdr_done_path = 1'b0;
        hdr_skip_n    = 8'd0;
        skip_hunt_n   = 16'd0;
        sub_eff       = sub_reg;
        res_valid     = 1'b0;
        res           = '0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (recent_reg == 16'd0 && byte_in == 8'd1) begin
                    phase_next = PH_CODE;
                end else begin
                    recent_next = {recent_reg[7:0], byte_in};
                end
            end
            PH_CODE: begin
                if (byte_in == CODE_PROGRAM_END) begin
                    req_hunt = 1'b1;
                    req_end  = 1'b1;
                end else if (byte_in == CODE_PACK) begin
                    phase_next = PH_PACK1;
                end else begin
                    sid_next   = byte_in;
                    phase_next = PH_LENHI;
                end
            end
            PH_PACK1: begin
                if (byte_in[7:6] == 2'b01) begin
                    field_next = 4'd1;
                    phase_next = PH_PACK2;
                end else if (byte_in[7:4] == 4'b0010) begin
                    req_skip_hunt = 1'b1;
                    skip_hunt_n   = PACK1_SKIP;
                end else begin
                    req_bad = 1'b1;
                end
            end
            PH_PACK2: begin
                if (field_reg >= PACK2_LAST_FIELD) begin
                    req_skip_hunt = 1'b1;
                    skip_hunt_n   = {13'd0, byte_in[2:0]};
                end else begin
                    field_next = field_reg + 4'd1;
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    req_hunt = 1'b1;
                end
            end
            PH_LENHI: begin
                skip_next  = {byte_in, 8'd0};
                phase_next = PH_LENLO;
            end
            PH_LENLO: begin
                pkt_len_next = lenlo_val;
                if (sid_reg == CODE_SYSTEM_HDR || is_reserved(sid_reg)) begin
                    req_skip_hunt = 1'b1;
                    skip_hunt_n   = lenlo_val;
                end else begin
                    hdr_used_next = 16'd0;
                    phase_next    = PH_PESFIRST;
                end
            end
            PH_PESFIRST: begin
                if (hdr_full) begin
                    req_bad = 1'b1;
                end else begin
                    hdr_used_next = hdr_used_reg + 16'd1;
                    if (byte_in[7:6] == 2'b10) begin
                        phase_next = PH_M2FLAGS2;
                    end else if (byte_in == BYTE_STUFFING) begin
                        phase_next = PH_M1STUFF;
                    end else if (byte_in[6]) begin
                        phase_next = PH_M1STD2;
                    end else begin
                        req_pts = 1'b1;
                    end
                end
            end
            PH_M2FLAGS2: begin
                if (hdr_full) begin
                    req_bad = 1'b1;
                end else begin
                    hdr_used_next = hdr_used_reg + 16'd1;
                    phase_next    = PH_M2HLEN;
                end
            end
            PH_M2HLEN: begin
                if (hdr_full) begin
                    req_bad = 1'b1;
                end else begin
                    hdr_used_next = hdr_used_reg + 16'd1;
                    if ({8'd0, byte_in} > left_after) begin
                        req_bad = 1'b1;
                    end else begin
                        req_hdr_skip = 1'b1;
                        hdr_skip_n   = byte_in;
                    end
                end
            end
            PH_HDRSKIP: begin
                if (hdr_full) begin
                    req_bad = 1'b1;
                end else begin
                    hdr_used_next = hdr_used_reg + 16'd1;
                    skip_next     = skip_dec;
                    if (skip_dec == 16'd0) begin
                        req_hdr_done = 1'b1;
                    end
                end
            end
            PH_M1STUFF: begin
                if (hdr_full) begin
                    req_bad = 1'b1;
                end else begin
                    hdr_used_next = hdr_used_reg + 16'd1;
                    if (byte_in == BYTE_STUFFING) begin
                        phase_next = PH_M1STUFF;
                    end else if (byte_in[6]) begin
                        phase_next = PH_M1STD2;
                    end else begin
                        req_pts = 1'b1;
                    end
                end
            end
            PH_M1STD2: begin
                if (hdr_full) begin
                    req_bad = 1'b1;
                end else begin
                    hdr_used_next = hdr_used_reg + 16'd1;
                    phase_next    = PH_M1PTS;
                end
            end
            PH_M1PTS: begin
                if (hdr_full) begin
                    req_bad = 1'b1;
                end else begin
                    hdr_used_next = hdr_used_reg + 16'd1;
                    req_pts       = 1'b1;
                end
            end
            PH_PRIV: begin
                if (hdr_full) begin
                    req_bad = 1'b1;
                end else begin
                    hdr_used_next = hdr_used_reg + 16'd1;
                    if (field_reg == 4'd0) begin
                        sub_next = byte_in;
                    end
                    if (field_reg >= PRIV_LAST_FIELD) begin
                        req_start = 1'b1;
                    end else begin
                        field_next = field_reg + 4'd1;
                    end
                end
            end
            PH_PAYLOAD: begin
                pay_rem_next = pay_dec;
                if (pay_dec == 16'd0) begin
                    req_hunt = 1'b1;
                end
                if (match_reg) begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_PAYLOAD;
                    res.data      = byte_in;
                    res.chunk_len = pkt_len_reg;
                    res.last      = (pay_dec == 16'd0);
                end
            end
            default: begin
                req_hunt = 1'b1;
            end
        endcase

        // Decode an MPEG-1 PTS/DTS flag byte
        if (req_pts) begin
            if (byte_in >= PTS_DTS_THRESHOLD) begin
                req_hdr_skip = 1'b1;
                hdr_skip_n   = PTS_DTS_BYTES;
            end else if (byte_in >= PTS_THRESHOLD) begin
                req_hdr_skip = 1'b1;
                hdr_skip_n   = PTS_BYTES;
            end else if (byte_in == PTS_NONE) begin
                req_hdr_done = 1'b1;
            end else begin
                req_bad = 1'b1;
            end
        end

        // Skip the rest of the header, or finish it at once
        if (req_hdr_skip) begin
            if (hdr_skip_n == 8'd0) begin
                req_hdr_done = 1'b1;
            end else begin
                skip_next  = {8'd0, hdr_skip_n};
                phase_next = PH_HDRSKIP;
            end
        end

        // Header finished: read the private stream fields or start payload
        if (req_hdr_done) begin
            if (sid_reg == SID_PRIVATE_1) begin
                field_next = 4'd0;
                phase_next = PH_PRIV;
            end else begin
                sub_next      = 8'd0;
                hdr_done_path = 1'b1;
                req_start     = 1'b1;
            end
        end

        // Latch the match and the payload length
        if (req_start) begin
            if (hdr_done_path) begin
                sub_eff = 8'd0;
            end
            match_next = (sid_reg == target_sid) && (sub_eff == target_sub);
            if (left_after == 16'd0) begin
                req_hunt = 1'b1;
            end else begin
                pkt_len_next = left_after;
                pay_rem_next = left_after;
                phase_next   = PH_PAYLOAD;
            end
        end

        // Skip a counted block, then hunt
        if (req_skip_hunt) begin
            if (skip_hunt_n == 16'd0) begin
                req_hunt = 1'b1;
            end else begin
                skip_next  = skip_hunt_n;
                phase_next = PH_SKIP;
            end
        end

        // Report the end code or a malformed header
        if (req_end) begin
            res_valid = 1'b1;
            res.kind  = KIND_END;
        end
        if (req_bad) begin
            req_hunt  = 1'b1;
            res_valid = 1'b1;
            res.kind  = KIND_MALFORMED;
        end

        // Resynchronise on the bytes that follow
        if (req_hunt) begin
            phase_next  = PH_HUNT;
            recent_next = 16'hFFFF;
        end

        if (!byte_valid) begin
            res_valid = 1'b0;
        end
    end

    // Advance the parse state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            recent_reg   <= 16'hFFFF;
            sid_reg      <= 8'd0;
            sub_reg      <= 8'd0;
            pkt_len_reg  <= 16'd0;
            hdr_used_reg <= 16'd0;
            skip_reg     <= 16'd0;
            field_reg    <= 4'd0;
            match_reg    <= 1'b0;
            pay_rem_reg  <= 16'd0;
        end else if (byte_valid) begin
            phase_reg    <= phase_next;
            recent_reg   <= recent_next;
            sid_reg      <= sid_next;
            sub_reg      <= sub_next;
            pkt_len_reg  <= pkt_len_next;
            hdr_used_reg <= hdr_used_next;
            skip_reg     <= skip_next;
            field_reg    <= field_next;
            match_reg    <= match_next;
            pay_rem_reg  <= pay_rem_next;
        end
    end

endmodule

FILE: hdl/psf_out_buf.sv
`timescale 1ns / 1ps

module psf_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  psf_pkg::psf_result_t push_data,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output psf_pkg::psf_result_t out_data
);
    import psf_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    psf_result_t out_data_reg;
    psf_result_t skid_data_reg;
    logic        pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: output slot plus one skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (out_valid_reg && !pop) begin
            if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end else begin
            out_valid_reg <= push;
        end
    end

    // Data: refill the output slot from the skid slot or the parser
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (out_valid_reg && !pop) begin
            if (push) begin
                skid_data_reg <= push_data;
            end
        end else if (push) begin
            out_data_reg <= push_data;
        end
    end

endmodule

FILE: hdl/program_stream_pes_filter.sv
// Program stream PES filter. Takes one byte of an MPEG-1/MPEG-2 program
// stream per clock while s_ready is high and passes on the payload bytes of
// the PES packets whose stream id and substream id match cfg registers 0 and
// 1, together with program end and malformed header events. Each byte is
// decoded combinationally by the header state machine, so a byte can be
// accepted on every such clock; results are registered in the two-slot result
// buffer between the parser and m_ before they leave, and s_ready drops only
// while both slots are full. No clearing pass follows reset.
`timescale 1ns / 1ps

module program_stream_pes_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_length,
    output logic        m_last_of_chunk
);
    import psf_pkg::*;

    `include "program_stream_pes_filter_assert.svh"

    logic [7:0]  target_sid_reg;
    logic [7:0]  target_sub_reg;
    logic        accept;
    logic        res_valid;
    psf_result_t res;
    psf_result_t out_res;
    logic        buf_space;
    logic        is_event_out;
    logic        is_payload_out;
    logic        ev_fields_zero;

    assign s_ready = buf_space;
    assign accept  = s_valid && buf_space;

    // Target registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_sid_reg <= TARGET_STREAM_RESET;
            target_sub_reg <= TARGET_SUBSTREAM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_STREAM:    target_sid_reg <= cfg_data;
                CFG_IDX_SUBSTREAM: target_sub_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    psf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (accept),
        .byte_in    (s_stream_byte),
        .target_sid (target_sid_reg),
        .target_sub (target_sub_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    psf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (buf_space),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_result_kind    = out_res.kind;
    assign m_payload_byte   = out_res.data;
    assign m_payload_length = out_res.chunk_len;
    assign m_last_of_chunk  = out_res.last;

    // Classify the offered result for the checks below
    assign is_event_out   = m_valid && (m_result_kind != KIND_PAYLOAD);
    assign is_payload_out = m_valid && (m_result_kind == KIND_PAYLOAD);
    assign ev_fields_zero = !m_last_of_chunk && (m_payload_length == 16'd0) &&
                            (m_payload_byte == 8'd0);

    `PSF_ASSERT(a_event_fields_clear, is_event_out |-> ev_fields_zero, "event carries payload fields")
    `PSF_ASSERT(a_payload_len_nonzero, is_payload_out |-> (m_payload_length != 16'd0), "zero length")
    `PSF_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_valid && s_ready), "not empty after reset")

endmodule
